[rtl/md5d_pkg.sv]
package md5d_pkg;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic        part_is_last;
   } rsp_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_add(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_rot(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] word_sel(input logic [5:0] r);
      logic [3:0] g;
      case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(5 * r[3:0] + 1);
         2'd2: g = 4'(3 * r[3:0] + 5);
         default: g = 4'(7 * r[3:0]);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

[rtl/md5d_block_ram.sv]
module md5d_block_ram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [16];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/md5d_round_core.sv]
module md5d_round_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         restart,
   input  logic [31:0]  word_data,
   output logic [3:0]   word_addr,
   output logic         busy,
   output logic [127:0] chain
);
   import md5d_pkg::*;

   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] h_ff [4];
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, fin_ff;
   logic [5:0]  r;
   logic [31:0] f, sum, rot;
   logic [5:0]  rd_r;

   assign r = cnt_ff[5:0] - 6'd1;
   assign rd_r = run_ff ? cnt_ff[5:0] : 6'd0;
   assign word_addr = word_sel(rd_r);
   assign busy = run_ff | fin_ff;
   assign chain = {h_ff[0], h_ff[1], h_ff[2], h_ff[3]};

   always_comb begin
      case (r[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + round_add(r) + word_data;
      rot = (sum << round_rot(r)) | (sum >> (6'd32 - {1'b0, round_rot(r)}));
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      cnt_in = cnt_ff; run_in = run_ff;
      if (start) begin
         a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
         cnt_in = 7'd0; run_in = 1'b1;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff != 7'd0) begin
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
         end
         if (cnt_ff == 7'd64) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= 7'd0;
         h_ff[0] <= INIT_A; h_ff[1] <= INIT_B; h_ff[2] <= INIT_C; h_ff[3] <= INIT_D;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         fin_ff <= run_ff & (cnt_ff == 7'd64);
         if (restart) begin
            h_ff[0] <= INIT_A; h_ff[1] <= INIT_B; h_ff[2] <= INIT_C; h_ff[3] <= INIT_D;
         end else if (fin_ff) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
         end
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff <= 7'd64) else $error("round count past end");
   a_fin_after: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !run_ff) else $error("finish while running");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart |-> !run_ff && !fin_ff) else $error("restart during compression");
`endif
endmodule

[rtl/md5_digest_unit.sv]
// A byte that fills a block holds ready low until its compression (load, all rounds
// and chain update) ends; a last item holds it low until both digest halves go out,
// after one or two compressions, each after padding writes to the rest of its block.
// Throughput: one byte per cycle inside a block while no compression runs, set by the
// one-round-per-cycle compression and the single block memory write port.
// Reset is synchronous and active high; it restores the initial chain and zero length.
module md5_digest_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  md5d_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output md5d_pkg::rsp_type  rsp_data
);
   import md5d_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_OUT0 = 3'd4;
   localparam logic [2:0] ST_OUT1 = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [63:0] total_ff, total_in;
   logic [31:0] word_ff, word_in;
   logic [5:0]  pos_ff, pos_in;
   logic        last_ff, last_in, two_ff, two_in;
   logic        wr_en, start, restart, busy, acc;
   logic [3:0]  wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data, pad_word;
   logic [127:0] chain;
   logic [63:0] bits;
   logic [5:0]  bpos;

   md5d_block_ram u_ram (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);
   md5d_round_core u_core (.clock, .reset, .start, .restart, .word_data(rd_data),
      .word_addr(rd_addr), .busy, .chain);

   assign acc = req_valid & req_ready;
   assign req_ready = (st_ff == ST_IDLE) & !busy;
   assign rsp_valid = (st_ff == ST_OUT0) | (st_ff == ST_OUT1);
   assign rsp_data.part_is_last = (st_ff == ST_OUT1);
   assign rsp_data.digest_part = (st_ff == ST_OUT1) ?
      {swap32(chain[63:32]), swap32(chain[31:0])} :
      {swap32(chain[127:96]), swap32(chain[95:64])};
   assign bpos = total_ff[5:0];
   assign bits = {total_ff[60:0], 3'b000};

   always_comb begin
      st_in = st_ff; total_in = total_ff; word_in = word_ff; pos_in = pos_ff;
      last_in = last_ff; two_in = two_ff;
      wr_en = 1'b0; wr_addr = bpos[5:2]; wr_data = word_ff; start = 1'b0; restart = 1'b0;
      pad_word = word_ff;
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               word_in = word_ff;
               pos_in = bpos;
               if (req_data.has_byte) begin
                  case (bpos[1:0])
                     2'd0: word_in = {24'd0, req_data.msg_byte};
                     2'd1: word_in[15:8] = req_data.msg_byte;
                     2'd2: word_in[23:16] = req_data.msg_byte;
                     default: word_in[31:24] = req_data.msg_byte;
                  endcase
                  wr_en = 1'b1; wr_addr = bpos[5:2]; wr_data = word_in;
                  total_in = total_ff + 64'd1;
                  pos_in = bpos + 6'd1;
                  if (bpos == 6'd63) begin
                     start = 1'b1;
                  end
               end
               if (req_data.is_last) begin
                  last_in = 1'b1;
                  two_in = (pos_in >= 6'd56);
                  st_in = (bpos == 6'd63 && req_data.has_byte) ? ST_WAIT : ST_PAD;
               end
            end
         end
         ST_WAIT: begin
            if (!busy) begin
               st_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // Pad byte if due, then zero words; the last block ends in the bit length.
            case (pos_ff[1:0])
               2'd0: pad_word = {24'd0, PAD_BYTE};
               2'd1: pad_word = {16'd0, PAD_BYTE, word_ff[7:0]};
               2'd2: pad_word = {8'd0, PAD_BYTE, word_ff[15:0]};
               default: pad_word = {PAD_BYTE, word_ff[23:0]};
            endcase
            wr_en = 1'b1;
            wr_addr = pos_ff[5:2];
            wr_data = (last_ff) ? pad_word : 32'd0;
            if (!two_ff && pos_ff[5:2] == 4'd14) wr_data = last_ff ? pad_word : bits[31:0];
            if (!two_ff && pos_ff[5:2] == 4'd15) wr_data = bits[63:32];
            last_in = 1'b0;
            pos_in = {pos_ff[5:2] + 4'd1, 2'b00};
            if (pos_ff[5:2] == 4'd15) begin
               st_in = ST_COMP;
               start = 1'b1;
            end
         end
         ST_COMP: begin
            if (!busy) begin
               if (two_ff) begin
                  two_in = 1'b0;
                  pos_in = 6'd0;
                  st_in = ST_PAD;
               end else begin
                  st_in = ST_OUT0;
               end
            end
         end
         ST_OUT0: begin
            if (rsp_ready) st_in = ST_OUT1;
         end
         ST_OUT1: begin
            if (rsp_ready) begin
               st_in = ST_IDLE;
               restart = 1'b1;
               total_in = 64'd0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         total_ff <= 64'd0;
         last_ff <= 1'b0;
         two_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         total_ff <= total_in;
         last_ff <= last_in;
         two_ff <= two_in;
      end
      word_ff <= word_in;
      pos_ff <= pos_in;
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_out_order: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT1) |-> $past(st_ff) == ST_OUT0 || $past(st_ff) == ST_OUT1)
      else $error("second half without first");
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("digest shown during compression");
`endif
endmodule
